// ----- rtl/falu_pkg.sv -----
`default_nettype none
package falu_pkg;

  localparam int FRAC_BITS = 8;
  // dividend magnitude is |a| << FRAC_BITS, up to 2^(31+FRAC_BITS)
  localparam int NUM_W = 32 + FRAC_BITS;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_GT   = 4'd4;
  localparam logic [3:0] OP_LT   = 4'd5;
  localparam logic [3:0] OP_GE   = 4'd6;
  localparam logic [3:0] OP_LE   = 4'd7;
  localparam logic [3:0] OP_EQ   = 4'd8;
  localparam logic [3:0] OP_NE   = 4'd9;
  localparam logic [3:0] OP_MIN  = 4'd10;
  localparam logic [3:0] OP_MAX  = 4'd11;
  localparam logic [3:0] OP_INC  = 4'd12;
  localparam logic [3:0] OP_DEC  = 4'd13;
  localparam logic [3:0] OP_FINT = 4'd14;
  localparam logic [3:0] OP_TINT = 4'd15;

  typedef struct packed {
    logic             valid;
    logic [3:0]       op;
    logic [31:0]      res;
    logic             cmp;
    logic             dz;
    logic             neg;
    logic [31:0]      divisor;
    logic [32:0]      rem;
    logic [NUM_W-1:0] num;
    logic [31:0]      quo;
  } pipe_t;

endpackage
`default_nettype wire

// ----- rtl/falu_front.sv -----
`default_nettype none
module falu_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [3:0]          opcode,
  input  wire logic signed [31:0]  operand_a,
  input  wire logic signed [31:0]  operand_b,
  output falu_pkg::pipe_t          stage,
  output logic signed [63:0]       prod
);

  falu_pkg::pipe_t stage_next;
  logic [31:0] abs_a;
  logic [31:0] abs_b;

  always_comb begin
    abs_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    abs_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;
    stage_next = '0;
    stage_next.valid = in_valid;
    stage_next.op = opcode;
    stage_next.divisor = abs_b;
    stage_next.num = {abs_a, {falu_pkg::FRAC_BITS{1'b0}}};
    stage_next.neg = operand_a[31] ^ operand_b[31];
    stage_next.dz = (opcode == falu_pkg::OP_DIV) && (operand_b == 32'sd0);
    unique case (opcode)
      falu_pkg::OP_ADD:  stage_next.res = operand_a + operand_b;
      falu_pkg::OP_SUB:  stage_next.res = operand_a - operand_b;
      falu_pkg::OP_GT:   stage_next.cmp = operand_a > operand_b;
      falu_pkg::OP_LT:   stage_next.cmp = operand_a < operand_b;
      falu_pkg::OP_GE:   stage_next.cmp = operand_a >= operand_b;
      falu_pkg::OP_LE:   stage_next.cmp = operand_a <= operand_b;
      falu_pkg::OP_EQ:   stage_next.cmp = operand_a == operand_b;
      falu_pkg::OP_NE:   stage_next.cmp = operand_a != operand_b;
      falu_pkg::OP_MIN:  stage_next.res = (operand_a < operand_b) ? operand_a : operand_b;
      falu_pkg::OP_MAX:  stage_next.res = (operand_a > operand_b) ? operand_a : operand_b;
      falu_pkg::OP_INC:  stage_next.res = operand_a + 32'sd1;
      falu_pkg::OP_DEC:  stage_next.res = operand_a - 32'sd1;
      falu_pkg::OP_FINT: stage_next.res = operand_a <<< falu_pkg::FRAC_BITS;
      falu_pkg::OP_TINT: stage_next.res = operand_a >>> falu_pkg::FRAC_BITS;
      default:           stage_next.res = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
      prod <= operand_a * operand_b;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/falu_div_step.sv -----
`default_nettype none
module falu_div_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire falu_pkg::pipe_t din,
  output falu_pkg::pipe_t      dout
);

  falu_pkg::pipe_t dout_next;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  // one restoring-division quotient bit per stage
  always_comb begin
    rem_sh = {din.rem[31:0], din.num[falu_pkg::NUM_W-1]};
    diff = {1'b0, rem_sh} - {2'b00, din.divisor};
    dout_next = din;
    dout_next.num = {din.num[falu_pkg::NUM_W-2:0], 1'b0};
    dout_next.rem = diff[33] ? rem_sh : diff[32:0];
    dout_next.quo = {din.quo[30:0], ~diff[33]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu.sv -----
// An item passes the front register, the divider steps and the output register.
// Throughput: one item per cycle unless the output stalls; the divider retires one quotient bit per stage.
// All operations travel the same pipeline, so results leave in order.
// A stall at the output freezes the whole pipeline.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module fixed_point_alu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         opcode,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      result_value,
  output logic                    compare_true,
  output logic                    divide_by_zero
);

  logic en;
  falu_pkg::pipe_t front;
  logic signed [63:0] prod;
  falu_pkg::pipe_t chain [0:falu_pkg::NUM_W];
  falu_pkg::pipe_t last;
  logic [31:0] res_next;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  falu_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .opcode(opcode),
    .operand_a(operand_a), .operand_b(operand_b), .stage(front), .prod(prod)
  );

  always_comb begin
    chain[0] = front;
    if (front.op == falu_pkg::OP_MUL) begin
      chain[0].res = prod[falu_pkg::FRAC_BITS+31:falu_pkg::FRAC_BITS];
    end
  end

  for (genvar i = 0; i < falu_pkg::NUM_W; i++) begin : g_div
    falu_div_step u_step (
      .clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1])
    );
  end

  assign last = chain[falu_pkg::NUM_W];

  always_comb begin
    res_next = last.res;
    if (last.op == falu_pkg::OP_DIV) begin
      if (last.dz) begin
        res_next = 32'd0;
      end else begin
        res_next = last.neg ? (32'd0 - last.quo) : last.quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
      result_value <= res_next;
      compare_true <= last.cmp;
      divide_by_zero <= last.dz;
    end
  end

endmodule
`default_nettype wire
